// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/oale_pkg.sv
// Shared codes and types of the ordered array list engine.
// No dependencies.
package oale_pkg;

    localparam int ACTION_BITS = 2;
    localparam int POS_BITS    = 7;
    localparam int STATUS_BITS = 2;
    localparam int FOUND_BITS  = 6;
    localparam int COUNT_BITS  = 7;

    localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_FIND   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_ILLEGAL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [POS_BITS-1:0]    position;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FOUND_BITS-1:0]  found_position;
        logic [COUNT_BITS-1:0]  entry_count;
    } t_res;

endpackage

// File: rtl/oale_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/oale_engine.sv
// Sequencer of the list engine: walks the store through the RAM, shifting or scanning entries
// for insert, delete and find, one request at a time. Depends on oale_pkg and oale_ram.
module oale_engine #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  oale_pkg::t_req        i_req,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_idle,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output oale_pkg::t_res        o_res
);
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > oale_pkg::POS_BITS) ? CW : oale_pkg::POS_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_UPEND = 3'd2;
    localparam logic [2:0] S_WVAL  = 3'd3;
    localparam logic [2:0] S_DOWN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_FIND  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                        r_state, n_state;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [CW-1:0]                     r_ptr, n_ptr;
    logic [CW-1:0]                     r_tag, n_tag;
    logic [CW-1:0]                     r_pos, n_pos;
    logic                              r_rvld, n_rvld;
    logic [VALUE_BITS-1:0]             r_val, n_val;
    logic [oale_pkg::STATUS_BITS-1:0]  r_status, n_status;
    logic [oale_pkg::FOUND_BITS-1:0]   r_found, n_found;

    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic [PW-1:0] w_pos_x;
    logic [PW-1:0] w_cnt_x;

    assign w_pos_x = PW'(i_req.position);
    assign w_cnt_x = PW'(r_cnt);

    oale_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_tag     = r_tag;
        n_pos     = r_pos;
        n_rvld    = 1'b0;
        n_val     = r_val;
        n_status  = r_status;
        n_found   = r_found;
        mem_we    = 1'b0;
        mem_waddr = r_tag[ADDR_BITS-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_ptr[ADDR_BITS-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = i_value;
                    n_pos    = CW'(i_req.position);
                    n_status = oale_pkg::ST_OK;
                    n_found  = '0;
                    case (i_req.action)
                        oale_pkg::ACT_INSERT: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_status = oale_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (w_pos_x > w_cnt_x) begin
                                n_status = oale_pkg::ST_ILLEGAL;
                                n_state  = S_DONE;
                            end else if (w_pos_x == w_cnt_x) begin
                                n_state = S_WVAL;
                            end else begin
                                n_ptr   = r_cnt - 1'b1;
                                n_state = S_UP;
                            end
                        end
                        oale_pkg::ACT_DELETE: begin
                            if (w_pos_x >= w_cnt_x) begin
                                n_status = oale_pkg::ST_ILLEGAL;
                                n_state  = S_DONE;
                            end else if (PW'(w_pos_x + 1'b1) == w_cnt_x) begin
                                n_cnt   = r_cnt - 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_ptr   = CW'(i_req.position) + 1'b1;
                                n_state = S_DOWN;
                            end
                        end
                        oale_pkg::ACT_FIND: begin
                            if (r_cnt == '0) begin
                                n_status = oale_pkg::ST_NOTFOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                mem_we = r_rvld;
                mem_re = 1'b1;
                n_rvld = 1'b1;
                n_tag  = r_ptr + 1'b1;
                if (r_ptr == r_pos) begin
                    n_state = S_UPEND;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            S_UPEND: begin
                mem_we  = r_rvld;
                n_state = S_WVAL;
            end
            S_WVAL: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[ADDR_BITS-1:0];
                mem_wdata = r_val;
                n_cnt     = r_cnt + 1'b1;
                n_state   = S_DONE;
            end
            S_DOWN: begin
                mem_we = r_rvld;
                mem_re = 1'b1;
                n_rvld = 1'b1;
                n_tag  = r_ptr - 1'b1;
                if (r_ptr == r_cnt - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DRAIN: begin
                mem_we  = r_rvld;
                n_cnt   = r_cnt - 1'b1;
                n_state = S_DONE;
            end
            S_FIND: begin
                if (r_rvld && mem_rdata == r_val) begin
                    n_status = oale_pkg::ST_OK;
                    n_found  = oale_pkg::FOUND_BITS'(r_tag);
                    n_state  = S_DONE;
                end else if (r_rvld && r_tag == r_cnt - 1'b1) begin
                    n_status = oale_pkg::ST_NOTFOUND;
                    n_state  = S_DONE;
                end else if (r_ptr < r_cnt) begin
                    mem_re = 1'b1;
                    n_rvld = 1'b1;
                    n_tag  = r_ptr;
                    n_ptr  = r_ptr + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rvld  <= n_rvld;
        end
        r_ptr    <= n_ptr;
        r_tag    <= n_tag;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status:         r_status,
                           found_position: r_found,
                           entry_count:    oale_pkg::COUNT_BITS'(r_cnt)};

endmodule

// File: rtl/ordered_array_list_engine_top.sv
// Ordered array list engine: an ordered list of values in one RAM with a use count.
// An item is taken only while the engine is idle. An insert shifts the entries from the
// end down to the given position and then writes the value; a delete shifts the later
// entries down and lowers the count; a find scans from position 0 until a match or the
// end; a rejected or unused request goes straight to its result. The result moves into
// the output register, and the next item can be taken in the cycle after that handoff.
// The single RAM does one read and one write per cycle while entries shift.
// Depends on oale_pkg, oale_engine, oale_ram and assert_macros.svh.
module ordered_array_list_engine_top #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_found_position,
    output logic [6:0]  o_entry_count
);
    logic                  w_idle;
    logic                  w_start;
    oale_pkg::t_req        w_req;
    logic [63:0]           w_val_x;
    logic                  w_res_valid;
    logic                  w_res_ready;
    oale_pkg::t_res        w_res;

    logic                  r_out_valid;
    oale_pkg::t_res        r_out;

    assign o_in_stall = !w_idle;
    assign w_start    = i_in_valid && w_idle;
    assign w_req      = '{action: i_action, position: i_position};
    assign w_val_x    = {{32{i_value[31]}}, i_value};

    oale_engine #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_req       (w_req),
        .i_value     (w_val_x[VALUE_BITS-1:0]),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found_position;
    assign o_entry_count    = r_out.entry_count;

`include "assert_macros.svh"

    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `AST_NEXT(a_idle_after_handoff, i_clk, i_rst_n, w_res_valid && w_res_ready, !o_in_stall)
    `AST_IMPLY(a_full_count, i_clk, i_rst_n, o_out_valid && o_status == oale_pkg::ST_FULL, o_entry_count == 7'(DEPTH))
    `AST_IMPLY(a_notfound_zero, i_clk, i_rst_n, o_out_valid && o_status == oale_pkg::ST_NOTFOUND, o_found_position == 6'd0)

endmodule

// File: tb/sv/oale_list_checker.sv
// Checker for the ordered array list engine: keeps its own copy of the list,
// predicts one result per accepted item and compares it field by field with the output.
// Depends on oale_pkg.
module oale_list_checker #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_found_position,
    input  logic [6:0]  i_entry_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]      list_vals [DEPTH];
    int               list_len      = 0;
    oale_pkg::t_res   expected_q [$];
    int               fail_count    = 0;
    int               pending_n     = 0;
    int               checked_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_checked    = checked_count;

    function automatic oale_pkg::t_res predict_list_op(input logic [1:0] act,
                                                       input logic [31:0] val,
                                                       input int pos);
        oale_pkg::t_res r;
        r.status         = oale_pkg::ST_OK;
        r.found_position = '0;
        case (act)
            oale_pkg::ACT_INSERT: begin
                if (list_len >= DEPTH) begin
                    r.status = oale_pkg::ST_FULL;
                end else if (pos > list_len) begin
                    r.status = oale_pkg::ST_ILLEGAL;
                end else begin
                    for (int k = list_len; k > pos; k--) list_vals[k] = list_vals[k-1];
                    list_vals[pos] = val;
                    list_len++;
                end
            end
            oale_pkg::ACT_DELETE: begin
                if (pos >= list_len) begin
                    r.status = oale_pkg::ST_ILLEGAL;
                end else begin
                    for (int k = pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            oale_pkg::ACT_FIND: begin
                r.status = oale_pkg::ST_NOTFOUND;
                for (int k = 0; k < list_len; k++) begin
                    if (r.status == oale_pkg::ST_NOTFOUND && list_vals[k] == val) begin
                        r.status         = oale_pkg::ST_OK;
                        r.found_position = k[5:0];
                    end
                end
            end
            default: ;  // unused code: list untouched
        endcase
        r.entry_count = list_len[6:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // outputs are retired before inputs so a same-edge item never meets its own result
    always @(posedge i_clk) begin : watch
        oale_pkg::t_res want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: status %0d, found %0d, count %0d",
                             $time, i_status, i_found_position, i_entry_count);
                end else begin
                    want = expected_q.pop_front();
                    checked_count++;
                    check_field("status", 7'(want.status), 7'(i_status));
                    check_field("found_position", 7'(want.found_position),
                                7'(i_found_position));
                    check_field("entry_count", want.entry_count, i_entry_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_list_op(i_action, i_value, int'(i_position)));
        end
        pending_n = expected_q.size();
    end

endmodule

// File: tb/sv/tb_ordered_array_list_engine_top.sv
// Testbench top for the ordered array list engine: clock, reset, item stimulus with
// random gaps and output stalls, and the verdict. Depends on oale_pkg, the engine RTL
// and oale_list_checker.
module tb_ordered_array_list_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              DEPTH        = 64;
    localparam int              CLK_PERIOD   = 8;
    localparam int              RESET_CYCLES = 12;
    localparam int              CYCLE_LIMIT  = 1_000_000;
    localparam int              DRAIN_CYCLES = 100;
    localparam int              LONG_HOLD    = 300;
    localparam int              ITEM_TARGET  = 950;
    localparam int              POOL_SIZE    = 8;
    localparam logic [1:0]      ACT_UNUSED   = 2'd3;

    typedef enum {ROUND_GROW, ROUND_SHRINK, ROUND_MIX, ROUND_NOISE} t_round_kind;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  action    = '0;
    logic [31:0] value     = '0;
    logic [6:0]  position  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic [6:0]  entry_count;

    int          fail_count;
    int          pending;
    int          checked;

    logic [31:0] value_pool [POOL_SIZE];
    int          est_len     = 0;
    int          sent_total  = 0;
    int          sent_by_act [4] = '{0, 0, 0, 0};
    int          full_hits   = 0;
    int          holds_done  = 0;
    int          cycles      = 0;
    bit          hold_req    = 1'b0;
    bit          tx_calm     = 1'b0;

    ordered_array_list_engine_top #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (32)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_action         (action),
        .i_value          (value),
        .i_position       (position),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_found_position (found_position),
        .o_entry_count    (entry_count)
    );

    oale_list_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_action         (action),
        .i_value          (value),
        .i_position       (position),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_found_position (found_position),
        .i_entry_count    (entry_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: short stalls, long stalls, stall-free stretches, one forced long hold
    initial begin : rx_side
        int len;
        int r;
        forever begin
            @(negedge clk);
            r = $urandom_range(0, 11);
            if (hold_req) begin
                out_stall <= 1'b1;
                len = LONG_HOLD;
                hold_req = 1'b0;
                holds_done++;
            end else if (r == 0) begin
                out_stall <= 1'b0;
                len = $urandom_range(50, 150);
            end else if (r < 7) begin
                out_stall <= 1'b0;
                len = $urandom_range(1, 6);
            end else if (r < 11) begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else begin
                out_stall <= 1'b1;
                len = $urandom_range(10, 40);
            end
            repeat (len - 1) @(negedge clk);
        end
    end

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input int act, input logic [31:0] val, input int pos);
        int         gap;
        int         r;
        logic [1:0] act2;
        logic [6:0] pos7;
        act2 = 2'(act);
        pos7 = 7'(pos);
        r = $urandom_range(0, 19);
        if (tx_calm || r < 10) gap = 0;
        else if (r < 17)       gap = $urandom_range(1, 3);
        else if (r < 19)       gap = $urandom_range(4, 10);
        else                   gap = $urandom_range(20, 60);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act2;
        value    <= val;
        position <= pos7;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        case (act2)
            oale_pkg::ACT_INSERT: begin
                if (est_len >= DEPTH) full_hits++;
                else if (int'(pos7) <= est_len) est_len++;
            end
            oale_pkg::ACT_DELETE: if (int'(pos7) < est_len) est_len--;
            default: ;
        endcase
        if (act2 != ACT_UNUSED) sent_total++;
        sent_by_act[act2]++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        int          r;
        int          n;
        t_round_kind kind;
        bit          first_round;
        bit          paused;
        bit          hold_armed;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int k = 5; k < POOL_SIZE; k++) value_pool[k] = $urandom;
        first_round = 1'b1;
        paused      = 1'b0;
        hold_armed  = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, extremes, duplicates, bad positions, unused code
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 0);
        send_item(oale_pkg::ACT_FIND,   32'h0000_0005, 0);
        send_item(oale_pkg::ACT_INSERT, 32'h0000_0001, 1);
        send_item(oale_pkg::ACT_INSERT, 32'h8000_0000, 0);
        send_item(oale_pkg::ACT_INSERT, 32'h7FFF_FFFF, 1);
        send_item(oale_pkg::ACT_INSERT, 32'h0000_0000, 1);
        send_item(oale_pkg::ACT_INSERT, 32'hFFFF_FFFF, 0);
        send_item(oale_pkg::ACT_INSERT, 32'h0000_0000, 4);
        send_item(oale_pkg::ACT_INSERT, 32'h1234_5678, 127);
        send_item(oale_pkg::ACT_INSERT, 32'h1234_5678, 6);
        send_item(oale_pkg::ACT_FIND,   32'h0000_0000, 0);
        send_item(oale_pkg::ACT_FIND,   32'h8000_0000, 127);
        send_item(oale_pkg::ACT_FIND,   32'h7FFF_FFFF, 0);
        send_item(oale_pkg::ACT_FIND,   32'hFFFF_FFFF, 0);
        send_item(oale_pkg::ACT_FIND,   32'h0000_3039, 0);
        send_item(ACT_UNUSED,           32'hFFFF_FFFF, 127);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 5);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 127);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 4);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 0);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 1);
        send_item(oale_pkg::ACT_FIND,   32'h0000_0000, 0);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 0);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 0);
        send_item(oale_pkg::ACT_DELETE, 32'h0000_0000, 0);
        wait_drain();
        @(negedge clk);

        while (sent_total < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            if (first_round)  kind = ROUND_GROW;
            else if (r < 3)   kind = ROUND_GROW;
            else if (r < 6)   kind = ROUND_SHRINK;
            else if (r < 9)   kind = ROUND_MIX;
            else              kind = ROUND_NOISE;
            first_round = 1'b0;
            tx_calm = ($urandom_range(0, 3) == 0);

            if (!hold_armed && sent_total >= 300) begin
                hold_req   = 1'b1;
                hold_armed = 1'b1;
                tx_calm    = 1'b1;
            end
            if (!paused && sent_total >= 600) begin
                wait_drain();
                @(negedge clk);
                paused = 1'b1;
            end

            case (kind)
                ROUND_GROW: begin
                    n = 0;
                    while (n < 3) begin
                        if (est_len >= DEPTH) n++;
                        r = $urandom_range(0, 9);
                        if (r < 7)
                            send_item(oale_pkg::ACT_INSERT, pick_value(),
                                      $urandom_range(0, est_len));
                        else if (r < 8)
                            send_item(oale_pkg::ACT_FIND, pick_value(), $urandom);
                        else if (r < 9)
                            send_item(oale_pkg::ACT_DELETE, $urandom,
                                      est_len > 0 ? $urandom_range(0, est_len - 1) : 0);
                        else
                            send_item(oale_pkg::ACT_INSERT, $urandom, $urandom_range(0, 127));
                    end
                end
                ROUND_SHRINK: begin
                    n = 0;
                    while (n < 2) begin
                        if (est_len == 0) n++;
                        r = $urandom_range(0, 9);
                        if (r < 7)
                            send_item(oale_pkg::ACT_DELETE, $urandom,
                                      est_len > 0 ? $urandom_range(0, est_len - 1) : 0);
                        else if (r < 8)
                            send_item(oale_pkg::ACT_INSERT, pick_value(),
                                      $urandom_range(0, est_len));
                        else if (r < 9)
                            send_item(oale_pkg::ACT_FIND, pick_value(), $urandom);
                        else
                            send_item(oale_pkg::ACT_DELETE, $urandom, $urandom_range(0, 127));
                    end
                end
                ROUND_MIX: begin
                    n = $urandom_range(20, 40);
                    repeat (n) begin
                        r = $urandom_range(0, 9);
                        if (r < 3)
                            send_item(oale_pkg::ACT_INSERT, pick_value(),
                                      $urandom_range(0, est_len));
                        else if (r < 5)
                            send_item(oale_pkg::ACT_DELETE, $urandom,
                                      est_len > 0 ? $urandom_range(0, est_len - 1) : 0);
                        else if (r < 8)
                            send_item(oale_pkg::ACT_FIND, pick_value(), $urandom);
                        else if (r < 9)
                            send_item(oale_pkg::ACT_FIND, $urandom, $urandom);
                        else
                            send_item($urandom_range(0, 1), $urandom, $urandom_range(0, 127));
                    end
                end
                default: begin
                    repeat (10)
                        send_item($urandom_range(0, 3), $urandom, $urandom_range(0, 127));
                end
            endcase
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d list requests: %0d insert, %0d delete, %0d find, plus %0d unused codes.",
                 sent_total, sent_by_act[oale_pkg::ACT_INSERT],
                 sent_by_act[oale_pkg::ACT_DELETE], sent_by_act[oale_pkg::ACT_FIND],
                 sent_by_act[ACT_UNUSED]);
        $display("Compared %0d results; %0d inserts hit a full list; %0d long output holds.",
                 checked, full_hits, holds_done);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
